// ===== rtl/nat_pkg.sv =====
// Shared types and constants for the network address text parser.
// Used by the front classifier, the token queue and the back-end parser.
`default_nettype none

package nat_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

   // Character classes handed from the front to the back.
   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_SPACE,
      CLS_COLON,
      CLS_SLASH,
      CLS_DOT,
      CLS_NUL,
      CLS_OTHER,
      CLS_END
   } char_class_type;

   typedef struct packed {
      char_class_type       cls;
      logic [DIGIT_W-1:0]   digit;
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/nat_front.sv =====
// Front end: classifies each accepted input byte into a token.
// Depends on nat_pkg for the token type and character constants.
`default_nettype none

module nat_front (
   input  wire logic [nat_pkg::CHAR_W-1:0] char_code,
   input  wire logic                       end_marker,
   output nat_pkg::token_type              token
);

   logic [nat_pkg::CHAR_W-1:0] digit_offset;

   assign digit_offset = char_code - nat_pkg::CHAR_ZERO;

   always_comb begin
      token.digit = digit_offset[nat_pkg::DIGIT_W-1:0];
      priority if (end_marker) begin
         token.cls = nat_pkg::CLS_END;
      end else if (char_code == nat_pkg::CHAR_NUL) begin
         token.cls = nat_pkg::CLS_NUL;
      end else if (char_code >= nat_pkg::CHAR_ZERO && char_code <= nat_pkg::CHAR_NINE) begin
         token.cls = nat_pkg::CLS_DIGIT;
      end else if (char_code == nat_pkg::CHAR_SPACE ||
                   (char_code >= nat_pkg::CHAR_TAB && char_code <= nat_pkg::CHAR_CR)) begin
         token.cls = nat_pkg::CLS_SPACE;
      end else if (char_code == nat_pkg::CHAR_COLON) begin
         token.cls = nat_pkg::CLS_COLON;
      end else if (char_code == nat_pkg::CHAR_SLASH) begin
         token.cls = nat_pkg::CLS_SLASH;
      end else if (char_code == nat_pkg::CHAR_DOT) begin
         token.cls = nat_pkg::CLS_DOT;
      end else begin
         token.cls = nat_pkg::CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nat_queue.sv =====
// Short token queue between the front classifier and the back-end parser.
// Depends on nat_pkg for the token type.
`default_nettype none

module nat_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire nat_pkg::token_type push_token,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output nat_pkg::token_type      head_token
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   nat_pkg::token_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign not_empty  = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nat_back.sv =====
// Back-end parser: runs the address grammar on queued tokens, keeps the four
// accumulators and holds the result register. Depends on nat_pkg.
`default_nettype none

module nat_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        token_valid,
   input  wire nat_pkg::token_type          token,
   output logic                             token_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_zone_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_net_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_node_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_point_value,
   output logic                             rsp_status
);

   localparam int unsigned VW = nat_pkg::VALUE_W;
   localparam int unsigned PW = VW + 4;

   typedef enum logic [2:0] {
      PH_WS,
      PH_ZONE,
      PH_NET,
      PH_NODE,
      PH_POINT,
      PH_ERR,
      PH_DONE
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic          has_digit_ff, has_digit_in;
   logic [VW-1:0] zone_ff, zone_in;
   logic [VW-1:0] net_ff, net_in;
   logic [VW-1:0] node_ff, node_in;
   logic [VW-1:0] point_ff, point_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_zone_ff, rsp_zone_in;
   logic [VW-1:0] rsp_net_ff, rsp_net_in;
   logic [VW-1:0] rsp_node_ff, rsp_node_in;
   logic [VW-1:0] rsp_point_ff, rsp_point_in;
   logic          rsp_status_ff, rsp_status_in;

   logic          is_end, out_free, step, ok;
   logic [VW-1:0] acc_sel, acc_next;
   logic [PW-1:0] product;

   assign is_end    = (token.cls == nat_pkg::CLS_END);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign token_pop = token_valid && (!is_end || out_free);
   assign step      = token_pop;
   assign ok        = (phase_ff == PH_DONE) ||
                      ((phase_ff == PH_NODE || phase_ff == PH_POINT) && has_digit_ff);

   // One shared times-ten-plus-digit unit serves whichever segment is open.
   always_comb begin
      unique case (phase_ff)
         PH_NET:   acc_sel = net_ff;
         PH_NODE:  acc_sel = node_ff;
         PH_POINT: acc_sel = point_ff;
         default:  acc_sel = zone_ff;
      endcase
      product  = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} +
                 {{(PW - nat_pkg::DIGIT_W){1'b0}}, token.digit};
      acc_next = (product[PW-1:VW] != '0) ? nat_pkg::VALUE_MAX : product[VW-1:0];
   end

   always_comb begin
      phase_in      = phase_ff;
      has_digit_in  = has_digit_ff;
      zone_in       = zone_ff;
      net_in        = net_ff;
      node_in       = node_ff;
      point_in      = point_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_zone_in   = rsp_zone_ff;
      rsp_net_in    = rsp_net_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_point_in  = rsp_point_ff;
      rsp_status_in = rsp_status_ff;

      if (step) begin
         priority if (is_end) begin
            rsp_valid_in  = 1'b1;
            rsp_zone_in   = ok ? zone_ff : '0;
            rsp_net_in    = ok ? net_ff : '0;
            rsp_node_in   = ok ? node_ff : '0;
            rsp_point_in  = ok ? point_ff : '0;
            rsp_status_in = !ok;
            phase_in      = PH_WS;
            has_digit_in  = 1'b0;
            zone_in       = '0;
            net_in        = '0;
            node_in       = '0;
            point_in      = '0;
         end else if (phase_ff == PH_ERR || phase_ff == PH_DONE) begin
            // Everything up to the end transfer is ignored here.
         end else if (token.cls == nat_pkg::CLS_NUL) begin
            phase_in = ok ? PH_DONE : PH_ERR;
         end else begin
            unique case (phase_ff)
               PH_WS: begin
                  if (token.cls == nat_pkg::CLS_DIGIT) begin
                     phase_in     = PH_ZONE;
                     has_digit_in = 1'b1;
                     zone_in      = acc_next;
                  end else if (token.cls != nat_pkg::CLS_SPACE) begin
                     phase_in = PH_ERR;
                  end
               end
               PH_ZONE: begin
                  if (token.cls == nat_pkg::CLS_DIGIT) begin
                     has_digit_in = 1'b1;
                     zone_in      = acc_next;
                  end else if (token.cls == nat_pkg::CLS_COLON && has_digit_ff) begin
                     phase_in     = PH_NET;
                     has_digit_in = 1'b0;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NET: begin
                  if (token.cls == nat_pkg::CLS_DIGIT) begin
                     has_digit_in = 1'b1;
                     net_in       = acc_next;
                  end else if (token.cls == nat_pkg::CLS_SLASH && has_digit_ff) begin
                     phase_in     = PH_NODE;
                     has_digit_in = 1'b0;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_NODE: begin
                  if (token.cls == nat_pkg::CLS_DIGIT) begin
                     has_digit_in = 1'b1;
                     node_in      = acc_next;
                  end else if (token.cls == nat_pkg::CLS_DOT && has_digit_ff) begin
                     phase_in     = PH_POINT;
                     has_digit_in = 1'b0;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_POINT: begin
                  if (token.cls == nat_pkg::CLS_DIGIT) begin
                     has_digit_in = 1'b1;
                     point_in     = acc_next;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               default: begin
                  phase_in = PH_ERR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS;
         has_digit_ff <= 1'b0;
         zone_ff      <= '0;
         net_ff       <= '0;
         node_ff      <= '0;
         point_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         has_digit_ff <= has_digit_in;
         zone_ff      <= zone_in;
         net_ff       <= net_in;
         node_ff      <= node_in;
         point_ff     <= point_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_zone_ff   <= rsp_zone_in;
      rsp_net_ff    <= rsp_net_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_point_ff  <= rsp_point_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zone_value  = rsp_zone_ff;
   assign rsp_net_value   = rsp_net_ff;
   assign rsp_node_value  = rsp_node_ff;
   assign rsp_point_value = rsp_point_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/network_address_text_parser.sv =====
// Address text parser, zone:net/node[.point], one byte per transfer.
// Throughput: one byte per cycle unless an end token waits on a stalled result;
// the parser step (one shared times-ten accumulate unit) reads one token per cycle
// from the queue. With an empty queue and a free result register, an accepted end
// transfer is queued, then taken into the result register. A stalled result holds
// only end tokens back. Reset (synchronous) empties the queue, returns the parser
// to its start and clears the result valid; there is no clearing pass.
`default_nettype none

module network_address_text_parser #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [nat_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic                        req_end_marker,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_zone_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_net_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_node_value,
   output logic [nat_pkg::VALUE_W-1:0]      rsp_point_value,
   output logic                             rsp_status
);

   nat_pkg::token_type in_token;
   nat_pkg::token_type head_token;
   logic               queue_full;
   logic               queue_not_empty;
   logic               token_pop;

   assign req_stall = queue_full;

   nat_front u_front (
      .char_code  (req_char_code),
      .end_marker (req_end_marker),
      .token      (in_token)
   );

   nat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_token (in_token),
      .full       (queue_full),
      .pop        (token_pop),
      .not_empty  (queue_not_empty),
      .head_token (head_token)
   );

   nat_back u_back (
      .clock           (clock),
      .reset           (reset),
      .token_valid     (queue_not_empty),
      .token           (head_token),
      .token_pop       (token_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_zone_value  (rsp_zone_value),
      .rsp_net_value   (rsp_net_value),
      .rsp_node_value  (rsp_node_value),
      .rsp_point_value (rsp_point_value),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// ===== bench/address_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the address text parser: watches both channels, predicts each result
// from the accepted bytes and compares it field by field. Depends on nat_pkg.

module address_result_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic [nat_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic                         req_end_marker,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [nat_pkg::VALUE_W-1:0]  rsp_zone_value,
   input  wire logic [nat_pkg::VALUE_W-1:0]  rsp_net_value,
   input  wire logic [nat_pkg::VALUE_W-1:0]  rsp_node_value,
   input  wire logic [nat_pkg::VALUE_W-1:0]  rsp_point_value,
   input  wire logic                         rsp_status,
   output int                                pending_count,
   output int                                mismatch_count
);

   typedef enum logic [2:0] {
      SCAN_SPACE,
      SCAN_ZONE,
      SCAN_NET,
      SCAN_NODE,
      SCAN_POINT,
      SCAN_BAD,
      SCAN_DONE
   } scan_phase_type;

   typedef struct {
      logic [nat_pkg::VALUE_W-1:0] zone;
      logic [nat_pkg::VALUE_W-1:0] net;
      logic [nat_pkg::VALUE_W-1:0] node;
      logic [nat_pkg::VALUE_W-1:0] point;
      logic                        status;
   } address_type;

   scan_phase_type              scan_phase = SCAN_SPACE;
   logic                        seg_digit_seen = 1'b0;
   logic [nat_pkg::VALUE_W-1:0] zone_sum = '0;
   logic [nat_pkg::VALUE_W-1:0] net_sum = '0;
   logic [nat_pkg::VALUE_W-1:0] node_sum = '0;
   logic [nat_pkg::VALUE_W-1:0] point_sum = '0;

   address_type expected_addresses[$];
   address_type oldest_address;
   int          mismatches = 0;

   function automatic logic [nat_pkg::VALUE_W-1:0] times_ten_plus(
      input logic [nat_pkg::VALUE_W-1:0] sum,
      input logic [nat_pkg::CHAR_W-1:0]  ch);
      int unsigned wide;
      wide = sum * 10 + (ch - nat_pkg::CHAR_ZERO);
      if (wide > nat_pkg::VALUE_MAX)
         wide = nat_pkg::VALUE_MAX;
      return wide[nat_pkg::VALUE_W-1:0];
   endfunction

   task automatic clear_parser();
      scan_phase     = SCAN_SPACE;
      seg_digit_seen = 1'b0;
      zone_sum       = '0;
      net_sum        = '0;
      node_sum       = '0;
      point_sum      = '0;
   endtask

   task automatic advance_parser(input logic [nat_pkg::CHAR_W-1:0] ch, input logic fin);
      address_type addr;
      logic        ok;
      logic        digit;
      ok    = (scan_phase == SCAN_DONE) ||
              ((scan_phase == SCAN_NODE || scan_phase == SCAN_POINT) && seg_digit_seen);
      digit = (ch >= nat_pkg::CHAR_ZERO) && (ch <= nat_pkg::CHAR_NINE);
      if (fin) begin
         addr.zone   = ok ? zone_sum : '0;
         addr.net    = ok ? net_sum : '0;
         addr.node   = ok ? node_sum : '0;
         addr.point  = ok ? point_sum : '0;
         addr.status = !ok;
         expected_addresses.push_back(addr);
         clear_parser();
      end else if (scan_phase == SCAN_BAD || scan_phase == SCAN_DONE) begin
         // Bytes after an error or after a zero byte leave the state alone.
      end else if (ch == nat_pkg::CHAR_NUL) begin
         scan_phase = ok ? SCAN_DONE : SCAN_BAD;
      end else begin
         case (scan_phase)
            SCAN_SPACE: begin
               if (!(ch == nat_pkg::CHAR_SPACE ||
                     (ch >= nat_pkg::CHAR_TAB && ch <= nat_pkg::CHAR_CR))) begin
                  if (digit) begin
                     scan_phase     = SCAN_ZONE;
                     seg_digit_seen = 1'b1;
                     zone_sum       = times_ten_plus(zone_sum, ch);
                  end else begin
                     scan_phase = SCAN_BAD;
                  end
               end
            end
            SCAN_ZONE: begin
               if (digit) begin
                  seg_digit_seen = 1'b1;
                  zone_sum       = times_ten_plus(zone_sum, ch);
               end else if (ch == nat_pkg::CHAR_COLON && seg_digit_seen) begin
                  scan_phase     = SCAN_NET;
                  seg_digit_seen = 1'b0;
               end else begin
                  scan_phase = SCAN_BAD;
               end
            end
            SCAN_NET: begin
               if (digit) begin
                  seg_digit_seen = 1'b1;
                  net_sum        = times_ten_plus(net_sum, ch);
               end else if (ch == nat_pkg::CHAR_SLASH && seg_digit_seen) begin
                  scan_phase     = SCAN_NODE;
                  seg_digit_seen = 1'b0;
               end else begin
                  scan_phase = SCAN_BAD;
               end
            end
            SCAN_NODE: begin
               if (digit) begin
                  seg_digit_seen = 1'b1;
                  node_sum       = times_ten_plus(node_sum, ch);
               end else if (ch == nat_pkg::CHAR_DOT && seg_digit_seen) begin
                  scan_phase     = SCAN_POINT;
                  seg_digit_seen = 1'b0;
               end else begin
                  scan_phase = SCAN_BAD;
               end
            end
            default: begin
               if (digit) begin
                  seg_digit_seen = 1'b1;
                  point_sum      = times_ten_plus(point_sum, ch);
               end else begin
                  scan_phase = SCAN_BAD;
               end
            end
         endcase
      end
   endtask

   task automatic check_field(input string label, input logic [nat_pkg::VALUE_W-1:0] want,
                              input logic [nat_pkg::VALUE_W-1:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("%s mismatch at %0t: expected %0d, got %0d", label, $time, want, got);
         mismatches++;
      end
   endtask

   // Inputs and outputs are sampled at the edge, before any of that edge's updates land.
   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_addresses.delete();
      end else begin
         if (req_valid && !req_stall)
            advance_parser(req_char_code, req_end_marker);
         if (rsp_valid && !rsp_stall) begin
            if (expected_addresses.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result at %0t: %0d:%0d/%0d.%0d status %0d", $time,
                           rsp_zone_value, rsp_net_value, rsp_node_value, rsp_point_value,
                           rsp_status);
               mismatches++;
            end else begin
               oldest_address = expected_addresses.pop_front();
               check_field("zone", oldest_address.zone, rsp_zone_value);
               check_field("net", oldest_address.net, rsp_net_value);
               check_field("node", oldest_address.node, rsp_node_value);
               check_field("point", oldest_address.point, rsp_point_value);
               check_field("status", {15'd0, oldest_address.status}, {15'd0, rsp_status});
            end
         end
      end
      pending_count  <= expected_addresses.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== bench/network_address_text_parser_test.sv =====
`timescale 1ns / 1ps
// Top of the address text parser bench: clock, reset, byte stimulus and the verdict.
// Depends on nat_pkg, network_address_text_parser and address_result_checker.

module network_address_text_parser_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1550;
   localparam int QUIET_AFTER = 1350;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic [nat_pkg::CHAR_W-1:0]   req_char_code = '0;
   logic                         req_end_marker = 1'b0;
   logic                         rsp_stall = 1'b0;
   wire                          req_stall;
   wire                          rsp_valid;
   wire [nat_pkg::VALUE_W-1:0]   rsp_zone_value;
   wire [nat_pkg::VALUE_W-1:0]   rsp_net_value;
   wire [nat_pkg::VALUE_W-1:0]   rsp_node_value;
   wire [nat_pkg::VALUE_W-1:0]   rsp_point_value;
   wire                          rsp_status;
   int                           pending_count;
   int                           mismatch_count;

   int                           sent_items = 0;
   int                           text_count = 0;
   int                           cycle_count = 0;
   int                           stall_left = 0;
   logic                         quiet = 1'b0;
   logic                         sender_gaps = 1'b1;
   logic [nat_pkg::CHAR_W-1:0]   text_bytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   network_address_text_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_zone_value  (rsp_zone_value),
      .rsp_net_value   (rsp_net_value),
      .rsp_node_value  (rsp_node_value),
      .rsp_point_value (rsp_point_value),
      .rsp_status      (rsp_status)
   );

   address_result_checker result_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_code   (req_char_code),
      .req_end_marker  (req_end_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_zone_value  (rsp_zone_value),
      .rsp_net_value   (rsp_net_value),
      .rsp_node_value  (rsp_node_value),
      .rsp_point_value (rsp_point_value),
      .rsp_status      (rsp_status),
      .pending_count   (pending_count),
      .mismatch_count  (mismatch_count)
   );

   // The result side stalls in random bursts until the closing stretch.
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic push_item(input logic [nat_pkg::CHAR_W-1:0] ch, input logic fin);
      int gap;
      if (!quiet && sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= ch;
      req_end_marker <= fin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_items++;
   endtask

   task automatic send_text(input logic [nat_pkg::CHAR_W-1:0] end_ch);
      foreach (text_bytes[i])
         push_item(text_bytes[i], 1'b0);
      push_item(end_ch, 1'b1);
      text_bytes.delete();
   endtask

   // Lowers valid and holds off until every expected result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         text_bytes.push_back(s[i]);
   endtask

   function automatic logic [nat_pkg::CHAR_W-1:0] space_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? nat_pkg::CHAR_SPACE : nat_pkg::CHAR_TAB + 8'(k);
   endfunction

   // Mostly short numbers, now and then long enough to saturate.
   task automatic add_number();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      repeat (n) text_bytes.push_back(nat_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic build_address();
      repeat ($urandom_range(0, 2)) text_bytes.push_back(space_char());
      add_number();
      text_bytes.push_back(nat_pkg::CHAR_COLON);
      add_number();
      text_bytes.push_back(nat_pkg::CHAR_SLASH);
      add_number();
      if ($urandom_range(0, 1) == 1) begin
         text_bytes.push_back(nat_pkg::CHAR_DOT);
         add_number();
      end
      if ($urandom_range(0, 5) == 0) begin
         text_bytes.push_back(nat_pkg::CHAR_NUL);
         repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic break_address();
      case ($urandom_range(0, 3))
         0: text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         1: text_bytes.push_back(space_char());
         2: text_bytes.delete($urandom_range(0, text_bytes.size() - 1));
         default: begin
            text_bytes.delete();
            repeat ($urandom_range(0, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty text, then whitespace only: both invalid.
      send_text(8'hFF);
      text_bytes.push_back(nat_pkg::CHAR_CR);
      send_text(8'h00);
      // Saturated zone, then a zero byte that ends the text early.
      add_text("99999:0/1");
      text_bytes.push_back(nat_pkg::CHAR_NUL);
      text_bytes.push_back(8'hFF);
      send_text(8'hA5);
      // A stray byte drops into the error phase, which ignores what follows.
      add_text("1:2/");
      text_bytes.push_back(8'h80);
      send_text(8'h5A);
      // A point separator with no digits after it.
      add_text("3:4/5.");
      send_text(8'h00);

      while (sent_items < ITEM_TARGET) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         build_address();
         if ($urandom_range(0, 9) < 3)
            break_address();
         if (sent_items >= QUIET_AFTER)
            quiet <= 1'b1;
         if (text_count == 40)
            drain_results();
         send_text(8'($urandom_range(0, 255)));
         text_count++;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nat_pkg.sv
rtl/nat_front.sv
rtl/nat_queue.sv
rtl/nat_back.sv
rtl/network_address_text_parser.sv
bench/address_result_checker.sv
bench/network_address_text_parser_test.sv
